[hdl/afdc_pkg.sv]
package afdc_pkg;

  // Field widths
  localparam int unsigned ForceW  = 32;   // Q16.16 force sample
  localparam int unsigned DispW   = 32;   // Q8.24 displacement
  localparam int unsigned CoefW   = 32;   // Q2.30 coefficient
  localparam int unsigned BoundW  = 31;   // unsigned deadband and clamp bound
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  // Datapath widths
  localparam int unsigned SumW     = ForceW + 2;          // x + 2*f1 + f0
  localparam int unsigned InProdW  = SumW + CoefW;        // 66
  localparam int unsigned InShift  = 22;                  // Q16.16 * Q2.30 -> Q8.24
  localparam int unsigned InTermW  = InProdW - InShift;   // 44
  localparam int unsigned FbProdW  = DispW + CoefW;       // 64
  localparam int unsigned FbShift  = 30;                  // Q8.24 * Q2.30 -> Q8.24
  localparam int unsigned FbTermW  = FbProdW - FbShift;   // 34
  localparam int unsigned AccW     = InTermW + 1;         // 45

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_DEADBAND    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CLAMP_LIMIT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_INPUT  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GAIN_PREV   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_GAIN_OLDER  = 3'd4;

  // Reset values
  localparam logic [BoundW-1:0] DEADBAND_RST    = 31'd327680;     // 5.0 N
  localparam logic [BoundW-1:0] CLAMP_LIMIT_RST = 31'd25166;      // ~0.0015 m
  localparam logic [CoefW-1:0]  GAIN_INPUT_RST  = 32'd997281;
  localparam logic [CoefW-1:0]  GAIN_PREV_RST   = 32'd334643450;
  localparam logic [CoefW-1:0]  GAIN_OLDER_RST  = 32'd699206718;

endpackage

[hdl/admittance_filter_deadband_clamp.sv]
// Path: a sample is held in the input register, then in the result register,
//   from which it is presented on the master side.
// Throughput: one sample per cycle unless the result side stalls; the filter
//   state steps as a sample beyond the deadband moves into the result register.
// Backpressure: a stalled result holds the input register; once that is occupied
//   too, s_axis_tready_o drops. Reset (rst_ni low, asynchronous): both stages empty,
//   histories zero, and the configuration registers return to their defaults.
module admittance_filter_deadband_clamp import afdc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // input stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [ForceW-1:0]   s_axis_tdata_i,   // [31:0] force_diff
  // result stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [DispW-1:0]    m_axis_tdata_o,   // [31:0] displacement
  output logic                m_axis_tuser_o    // [0] active
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [BoundW-1:0]       deadband_q, clamp_q;
  logic signed [CoefW-1:0] gain_in_q, gain_prev_q, gain_older_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q   <= DEADBAND_RST;
      clamp_q      <= CLAMP_LIMIT_RST;
      gain_in_q    <= GAIN_INPUT_RST;
      gain_prev_q  <= GAIN_PREV_RST;
      gain_older_q <= GAIN_OLDER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEADBAND:    deadband_q   <= cfg_wdata_i[BoundW-1:0];
        REG_CLAMP_LIMIT: clamp_q      <= cfg_wdata_i[BoundW-1:0];
        REG_GAIN_INPUT:  gain_in_q    <= cfg_wdata_i;
        REG_GAIN_PREV:   gain_prev_q  <= cfg_wdata_i;
        REG_GAIN_OLDER:  gain_older_q <= cfg_wdata_i;
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage control: input register feeds the result register. The input stage
  // advances whenever the result register is empty or being drained.
  // ---------------------------------------------------------------------------
  logic in_valid_q, out_valid_q;
  logic advance, step;
  logic signed [ForceW-1:0] x_q;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      x_q <= s_axis_tdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Deadband test: step only when |x| is strictly beyond the threshold.
  // ---------------------------------------------------------------------------
  logic signed [ForceW:0] x_ext, db_pos, db_neg;
  logic                   outside;

  assign x_ext   = {x_q[ForceW-1], x_q};
  assign db_pos  = {2'b00, deadband_q};
  assign db_neg  = -db_pos;
  assign outside = (x_ext > db_pos) || (x_ext < db_neg);
  assign step    = in_valid_q && advance && outside;

  // ---------------------------------------------------------------------------
  // Filter state
  // ---------------------------------------------------------------------------
  logic signed [ForceW-1:0] f1_q, f0_q;   // newest, older force sample
  logic signed [DispW-1:0]  d1_q, d0_q;   // newest, older displacement
  logic signed [DispW-1:0]  y_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_q <= '0;
      f0_q <= '0;
      d1_q <= '0;
      d0_q <= '0;
    end else if (step) begin
      // shift both histories one place
      f0_q <= f1_q;
      f1_q <= x_q;
      d0_q <= d1_q;
      d1_q <= y_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // Admittance step: three independent multiplies, each floored to Q8.24 by
  // dropping low bits (arithmetic shift rounds toward minus infinity).
  // ---------------------------------------------------------------------------
  logic signed [SumW-1:0]    fsum;
  logic signed [InProdW-1:0] prod_in;
  logic signed [FbProdW-1:0] prod_prev, prod_older;
  logic signed [InTermW-1:0] term_in;
  logic signed [FbTermW-1:0] term_prev, term_older;
  logic signed [AccW-1:0]    acc, lim_pos, lim_neg;

  assign fsum = {{2{x_q[ForceW-1]}}, x_q}
              + {f1_q[ForceW-1], f1_q, 1'b0}
              + {{2{f0_q[ForceW-1]}}, f0_q};

  assign prod_in    = fsum * gain_in_q;
  assign prod_prev  = d1_q * gain_prev_q;
  assign prod_older = d0_q * gain_older_q;

  assign term_in    = prod_in[InProdW-1:InShift];
  assign term_prev  = prod_prev[FbProdW-1:FbShift];
  assign term_older = prod_older[FbProdW-1:FbShift];

  assign acc = {term_in[InTermW-1], term_in}
             + {{(AccW-FbTermW){term_prev[FbTermW-1]}}, term_prev}
             + {{(AccW-FbTermW){term_older[FbTermW-1]}}, term_older};

  // saturate to +/- clamp bound; the bound always fits the output width
  assign lim_pos = {{(AccW-BoundW){1'b0}}, clamp_q};
  assign lim_neg = -lim_pos;

  always_comb begin
    if (acc > lim_pos) begin
      y_sat = lim_pos[DispW-1:0];
    end else if (acc < lim_neg) begin
      y_sat = lim_neg[DispW-1:0];
    end else begin
      y_sat = acc[DispW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [DispW-1:0] disp_q;
  logic             act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      disp_q <= outside ? y_sat : '0;   // zero inside the deadband
      act_q  <= outside;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = disp_q;
  assign m_axis_tuser_o  = act_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // An idle result stage never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready_o)
    else $error("input stalled with empty result register");

  // Inside the deadband the displacement is zero.
  a_zero_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("nonzero displacement without a filter step");

  // Delivered displacement stays within the clamp bound.
  a_within_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (($signed(m_axis_tdata_o) <= $signed({1'b0, clamp_q})) &&
       ($signed(m_axis_tdata_o) >= -$signed({1'b0, clamp_q}))))
    else $error("displacement beyond clamp bound");

  // The displacement history moves only on a filter step, and then it holds the
  // value sent to the result register.
  a_hist_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> (d1_q == disp_q) && act_q && out_valid_q)
    else $error("history and result disagree after a step");

  a_hist_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(d1_q) && $stable(f1_q))
    else $error("filter state changed without a step");

endmodule

[tb/sv/afdc_motion_checker.sv]
module afdc_motion_checker import afdc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_i,
  input  logic [ForceW-1:0]   s_axis_tdata_i,   // [31:0] force_diff
  input  logic                m_axis_tvalid_i,
  input  logic                m_axis_tready_i,
  input  logic [DispW-1:0]    m_axis_tdata_i,   // [31:0] displacement
  input  logic                m_axis_tuser_i,   // [0] active
  output int                  errors_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [DispW-1:0] displacement;
    logic             active;
  } motion_t;

  logic [BoundW-1:0]        band_q;
  logic [BoundW-1:0]        limit_q;
  logic signed [CoefW-1:0]  gain_in_q;
  logic signed [CoefW-1:0]  gain_prev_q;
  logic signed [CoefW-1:0]  gain_older_q;
  logic signed [ForceW-1:0] force_hist [2];   // index 1 is newest
  logic signed [DispW-1:0]  disp_hist [2];
  motion_t                  motion_q [$];
  motion_t                  want;
  int                       mismatches = 0;

  function automatic void flag(string what, logic [DispW-1:0] exp_v, logic [DispW-1:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s mismatch: expected %h, got %h", $time, what, exp_v, got_v);
  endfunction

  // Model one accepted sample; the histories move only beyond the deadband.
  function automatic motion_t step_filter(logic signed [ForceW-1:0] x);
    longint                    db;
    longint                    lim;
    longint                    sum;
    longint                    acc;
    longint                    fb;
    logic signed [InProdW-1:0] in_prod;
    motion_t                   m;
    db  = longint'(band_q);
    lim = longint'(limit_q);
    m   = '0;
    if (!(x > db || x < -db))
      return m;
    sum     = longint'(x) + 2 * longint'(force_hist[1]) + longint'(force_hist[0]);
    in_prod = sum * gain_in_q;
    acc     = longint'(in_prod >>> InShift);
    fb      = longint'(gain_prev_q) * longint'(disp_hist[1]);
    acc    += fb >>> FbShift;
    fb      = longint'(gain_older_q) * longint'(disp_hist[0]);
    acc    += fb >>> FbShift;
    if (acc > lim)
      acc = lim;
    if (acc < -lim)
      acc = -lim;
    force_hist[0] = force_hist[1];
    force_hist[1] = x;
    disp_hist[0]  = disp_hist[1];
    disp_hist[1]  = acc[DispW-1:0];
    m.displacement = acc[DispW-1:0];
    m.active       = 1'b1;
    return m;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      band_q       = DEADBAND_RST;
      limit_q      = CLAMP_LIMIT_RST;
      gain_in_q    = GAIN_INPUT_RST;
      gain_prev_q  = GAIN_PREV_RST;
      gain_older_q = GAIN_OLDER_RST;
      force_hist   = '{default: '0};
      disp_hist    = '{default: '0};
      motion_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DEADBAND:    band_q       = cfg_wdata_i[BoundW-1:0];
          REG_CLAMP_LIMIT: limit_q      = cfg_wdata_i[BoundW-1:0];
          REG_GAIN_INPUT:  gain_in_q    = cfg_wdata_i;
          REG_GAIN_PREV:   gain_prev_q  = cfg_wdata_i;
          REG_GAIN_OLDER:  gain_older_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        motion_q.push_back(step_filter(s_axis_tdata_i));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (motion_q.size() == 0) begin
          flag("unexpected result", '0, m_axis_tdata_i);
        end else begin
          want = motion_q.pop_front();
          if (m_axis_tdata_i !== want.displacement)
            flag("displacement", want.displacement, m_axis_tdata_i);
          if (m_axis_tuser_i !== want.active)
            flag("active", DispW'(want.active), DispW'(m_axis_tuser_i));
        end
      end
    end
    pending_o <= motion_q.size();
    errors_o  <= mismatches;
  end

endmodule

[tb/sv/admittance_filter_deadband_clamp_tb.sv]
module admittance_filter_deadband_clamp_tb;
  import afdc_pkg::*;

  // Index past the end of the register map; the block must ignore it.
  localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;

  // Receiver stall patterns.
  typedef enum int {RxFree, RxCoin, RxComb, RxHold} rx_mode_e;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [ForceW-1:0]   s_tdata   = '0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [DispW-1:0]    m_tdata;
  logic                m_tuser;
  int                  errors;
  int                  pending;

  rx_mode_e            rx_mode   = RxFree;
  int                  rx_left   = 0;
  int                  burst_left = 0;
  logic [BoundW-1:0]   band;      // deadband currently programmed, for stimulus shaping

  always #5 clk = ~clk;

  admittance_filter_deadband_clamp dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  afdc_motion_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  // Receiver: switch at random between stall patterns so that back-pressure
  // lands on every phase of the pipeline, with free-running stretches in between.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RxFree:  m_tready <= 1'b1;
      RxCoin:  m_tready <= 1'($urandom_range(0, 1));
      RxComb:  m_tready <= (rx_left % 4) != 0;
      default: m_tready <= (rx_left % 16) >= 12;   // ready only when rx_left mod 16 is 12 or more
    endcase
  end

  // Present one force sample and hold it until the transfer completes. Insert
  // a random gap first whenever the current burst is used up.
  task automatic send_force(input logic [ForceW-1:0] f);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 10);
    end else begin
      burst_left--;
    end
    s_tvalid <= 1'b1;
    s_tdata  <= f;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Drop valid and wait until every expected result has been collected, then
  // let the pipeline go quiet.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Program the whole register map; only called while the block is idle.
  task automatic program_filter(input logic [CfgDataW-1:0] db, input logic [CfgDataW-1:0] lim,
                                input logic [CfgDataW-1:0] gi, input logic [CfgDataW-1:0] gp,
                                input logic [CfgDataW-1:0] go);
    put_reg(REG_DEADBAND, db);
    put_reg(REG_CLAMP_LIMIT, lim);
    put_reg(REG_GAIN_INPUT, gi);
    put_reg(REG_GAIN_PREV, gp);
    put_reg(REG_GAIN_OLDER, go);
    put_reg(RegSpare, $urandom);
    cfg_we <= 1'b0;
    band = db[BoundW-1:0];
  endtask

  // Mostly samples outside the band so the filter keeps stepping; some on the
  // band edges, some inside, some at the extremes and some fully random.
  function automatic logic [ForceW-1:0] pick_force(input logic [BoundW-1:0] db);
    longint d;
    longint v;
    d = longint'(db);
    case ($urandom_range(0, 9))
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0:       v = d;
          1:       v = d + 1;
          2:       v = -d;
          default: v = -d - 1;
        endcase
      end
      2: begin
        v = $urandom_range(0, db);
        if ($urandom_range(0, 1)) v = -v;
      end
      3: v = $urandom_range(0, 1) ? 64'sh7FFF_FFFF : -64'sh8000_0000;
      default: begin
        v = d + $urandom_range(1, 1 << 22);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v[ForceW-1:0];
  endfunction

  function automatic logic [CfgDataW-1:0] pick_gain(input logic [CoefW-1:0] nominal);
    case ($urandom_range(0, 3))
      0:       return nominal;
      1:       return nominal + $urandom_range(0, 1 << 20) - (1 << 19);
      2:       return $urandom;
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  initial begin
    logic [CfgDataW-1:0] db;
    logic [CfgDataW-1:0] lim;
    band = DEADBAND_RST;

    // Hold reset low from time zero, then release it on a clock edge.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: zero, both band edges (inside), just past them, full-scale
    // samples, a sample inside the band, then pushes that drive the output into the clamp.
    send_force(32'h0000_0000);
    send_force(32'h0005_0000);
    send_force(32'hFFFB_0000);
    send_force(32'h0005_0001);
    send_force(32'hFFFA_FFFF);
    send_force(32'h7FFF_FFFF);
    send_force(32'h8000_0000);
    send_force(32'h0001_0000);
    repeat (3) send_force(32'h0400_0000);
    repeat (3) send_force(32'hFC00_0000);
    settle();

    // No deadband, widest clamp, extreme gains: zero is the only idle sample,
    // and the sum overflows well past 32 bits before saturation.
    program_filter(32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_force(32'h0000_0000);
    send_force(32'h0000_0001);
    send_force(32'hFFFF_FFFF);
    send_force(32'h7FFF_FFFF);
    send_force(32'h7FFF_FFFF);
    send_force(32'h8000_0000);
    send_force(32'h8000_0000);
    send_force(32'h7FFF_FFFF);
    settle();

    // Widest deadband with the top data bit set (must be dropped) and a zero
    // clamp: only the most negative sample steps, and it answers zero.
    program_filter(32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_force(32'h7FFF_FFFF);
    send_force(32'h8000_0000);
    send_force(32'h0000_0000);
    send_force(32'h8000_0000);
    settle();

    // Random phases, each with its own register settings.
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(0, 5))
        0:       db = $urandom;
        1:       db = 32'h0;
        2:       db = DEADBAND_RST;
        default: db = $urandom_range(0, 32'h000F_FFFF);
      endcase
      case ($urandom_range(0, 3))
        0:       lim = CLAMP_LIMIT_RST;
        1:       lim = $urandom;
        2:       lim = 32'h7FFF_FFFF;
        default: lim = $urandom_range(0, 1 << 24);
      endcase
      if (phase == 0)
        program_filter(db, lim, GAIN_INPUT_RST, GAIN_PREV_RST, GAIN_OLDER_RST);
      else
        program_filter(db, lim, pick_gain(GAIN_INPUT_RST), pick_gain(GAIN_PREV_RST),
                       pick_gain(GAIN_OLDER_RST));
      for (int n = 0; n < 155; n++) begin
        send_force(pick_force(band));
        // Hold off mid-phase until the pipeline has fully drained once.
        if (phase == 2 && n == 77)
          settle();
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog: end the run if the handshakes stop making progress.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
hdl/afdc_pkg.sv
hdl/admittance_filter_deadband_clamp.sv
tb/sv/afdc_motion_checker.sv
tb/sv/admittance_filter_deadband_clamp_tb.sv
